/* rtl/core/aes_pkg.sv */
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and functions of the AES block cipher
// Holds the S-boxes, GF(2^8) helpers and the configuration register indexes.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int SCHEDULE_WORDS = 60;
	localparam int KW_BITS = 6;

	typedef enum logic [2:0] {
		REG_KEY_SIZE = 3'd0,
		REG_KEY_0    = 3'd1,
		REG_KEY_1    = 3'd2,
		REG_KEY_2    = 3'd3,
		REG_KEY_3    = 3'd4
	} reg_idx_t;

	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;
	localparam logic [1:0] KS_256 = 2'd2;

	localparam logic       OP_ENC = 1'b0;
	localparam logic       OP_DEC = 1'b1;

	localparam logic [7:0] GF_POLY = 8'h1b;
	localparam logic [7:0] RCON_INIT = 8'h01;

	localparam logic [7:0] FWD_BOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_BOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] gf_dbl(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
	endfunction

endpackage

/* rtl/core/aes_if.sv */
// ----------------------------------------------------------------------------
// aes_if: valid/ready channel interfaces of the AES block cipher
// Data input, data output and configuration write channels.
// ----------------------------------------------------------------------------
interface aes_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [63:0] block_hi;
	logic [63:0] block_lo;
	modport source (output valid, opcode, block_hi, block_lo, input ready);
	modport sink (input valid, opcode, block_hi, block_lo, output ready);
endinterface

interface aes_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_hi;
	logic [63:0] result_lo;
	modport source (output valid, result_hi, result_lo, input ready);
	modport sink (input valid, result_hi, result_lo, output ready);
endinterface

interface aes_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/aes_ram.sv */
// ----------------------------------------------------------------------------
// aes_ram: generic single-port RAM with registered read
// One write or read per cycle; read data appears the cycle after the address.
// ----------------------------------------------------------------------------
module aes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* rtl/core/aes_round.sv */
// ----------------------------------------------------------------------------
// aes_round: shared round unit
// One forward or inverse round on the 128-bit state, plus the key addition.
// ----------------------------------------------------------------------------
module aes_round
	import aes_pkg::*;
(
	input  logic [127:0] state_in,
	input  logic [127:0] round_key,
	input  logic         inverse,
	input  logic         do_sub,
	input  logic         do_mix,
	output logic [127:0] state_out
);
	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] k [16];
	logic [7:0] m [16];
	logic [7:0] o [16];
	logic [7:0] c0, c1, c2, c3;
	logic [7:0] d0, d1, d2, d3, q0, q1, q2, q3;

	// byte s[r+4c] is row r, column c, byte 0 most significant
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state_in[127-8*i -: 8];
			k[i] = round_key[127-8*i -: 8];
		end
		// substitute and shift rows
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (!do_sub) begin
					t[r+4*c] = s[r+4*c];
				end else if (inverse) begin
					t[r+4*((c+r)%4)] = INV_BOX[s[r+4*c]];
				end else begin
					t[r+4*c] = FWD_BOX[s[r+4*((c+r)%4)]];
				end
			end
		end
		// forward: mix then key; inverse: key then mix
		for (int i = 0; i < 16; i++) begin
			k[i] = inverse ? (t[i] ^ k[i]) : t[i];
		end
		for (int c = 0; c < 4; c++) begin
			c0 = k[4*c]; c1 = k[4*c+1]; c2 = k[4*c+2]; c3 = k[4*c+3];
			d0 = gf_dbl(c0); d1 = gf_dbl(c1); d2 = gf_dbl(c2); d3 = gf_dbl(c3);
			q0 = gf_dbl(d0); q1 = gf_dbl(d1); q2 = gf_dbl(d2); q3 = gf_dbl(d3);
			if (inverse) begin
				// 0e,0b,0d,09 as the forward mix after adding 4*(a0^a2), 4*(a1^a3)
				c0 = k[4*c] ^ q0 ^ q2; c1 = k[4*c+1] ^ q1 ^ q3;
				c2 = k[4*c+2] ^ q0 ^ q2; c3 = k[4*c+3] ^ q1 ^ q3;
				d0 = gf_dbl(c0); d1 = gf_dbl(c1); d2 = gf_dbl(c2); d3 = gf_dbl(c3);
			end
			m[4*c]   = d0 ^ d1 ^ c1 ^ c2 ^ c3;
			m[4*c+1] = c0 ^ d1 ^ d2 ^ c2 ^ c3;
			m[4*c+2] = c0 ^ c1 ^ d2 ^ d3 ^ c3;
			m[4*c+3] = d0 ^ c0 ^ c1 ^ c2 ^ d3;
		end
		for (int i = 0; i < 16; i++) begin
			o[i] = do_mix ? m[i] : k[i];
			if (!inverse) begin
				o[i] = o[i] ^ round_key[127-8*i -: 8];
			end
			state_out[127-8*i -: 8] = o[i];
		end
	end
endmodule

/* rtl/core/aes_block_cipher.sv */
// ----------------------------------------------------------------------------
// aes_block_cipher: AES-128/192/256 block cipher, iterative
// Encrypts or decrypts one 128-bit block per item with a stored key schedule.
// ----------------------------------------------------------------------------
// After reset or any write to a valid register, the next item first expands
// the key into the schedule RAM: it stores the Nk key words, then reads w[i-Nk]
// and writes w[i] for each further word. A block then makes Nr+1 passes
// through the shared round unit, each reading the four key words through the
// single 32-bit RAM port, which sets the pace of a pass, and then doing one
// round in the round unit. The last step loads the output register, and the
// block returns to idle, where the next item is accepted.
// One item is handled at a time; the result is held in an output register
// while the next item is accepted, and the block waits in its last step until
// that register is free. Configuration is accepted only while idle with the
// output register empty, and a pending write holds off new input items.
module aes_block_cipher
	import aes_pkg::*;
#(
	parameter int WORDS = SCHEDULE_WORDS
) (
	input logic clk,
	input logic arst_n,
	aes_in_if.sink   in_ch,
	aes_out_if.source out_ch,
	aes_cfg_if.sink  cfg
);
	localparam int AW = $clog2(WORDS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXPRD = 6'b000010,
		ST_EXPWR = 6'b000100,
		ST_KRD   = 6'b001000,
		ST_ROUND = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t       st_q;
	logic [1:0]   ksize_q;
	logic [63:0]  key_q [4];
	logic         sched_ok_q;
	logic         op_q;
	logic [127:0] blk_q, rk_q;
	logic [3:0]   rnd_q;
	logic [2:0]   wcnt_q;
	logic [AW-1:0] widx_q;
	logic [2:0]   kphase_q;
	logic [7:0]   rcon_q;
	logic [31:0]  prev_q;
	logic         obusy_q;
	logic [127:0] res_q;

	logic [3:0]   nk, nr;
	logic         we;
	logic [AW-1:0] addr;
	logic [31:0]  wdata, rdata, t_w, new_w;
	logic [127:0] rnd_out;
	logic         first_rnd, last_rnd;
	logic [AW-1:0] total;
	logic [31:0]  kword;

	assign nk = (ksize_q == KS_128) ? 4'd4 : (ksize_q == KS_192) ? 4'd6 : 4'd8;
	assign nr = nk + 4'd6;
	assign total = AW'(4 * (nk + 7));
	assign kword = widx_q[0] ? key_q[widx_q[2:1]][31:0]
		: key_q[widx_q[2:1]][63:32];

	assign cfg.ready = (st_q == ST_IDLE) && !obusy_q;
	assign in_ch.ready = (st_q == ST_IDLE) && !cfg.valid;
	assign out_ch.valid = obusy_q;
	assign out_ch.result_hi = res_q[127:64];
	assign out_ch.result_lo = res_q[63:0];

	// next schedule word from w[i-1]=prev_q and w[i-nk]=rdata
	always_comb begin
		t_w = prev_q;
		if (kphase_q == 3'd0) begin
			t_w = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && kphase_q == 3'd4) begin
			t_w = sub_word(prev_q);
		end
		new_w = rdata ^ t_w;
	end

	// RAM port control
	always_comb begin
		we = 1'b0;
		wdata = new_w;
		addr = widx_q;
		case (st_q)
			ST_EXPRD: begin
				if (widx_q < AW'(nk)) begin
					we = 1'b1;
					wdata = kword;
				end else begin
					addr = widx_q - AW'(nk);
				end
			end
			ST_EXPWR: we = 1'b1;
			ST_KRD: addr = AW'(4 * (op_q ? nr - rnd_q : rnd_q)) + AW'(wcnt_q[1:0]);
			default: addr = widx_q;
		endcase
	end

	aes_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign first_rnd = (rnd_q == 4'd0);
	assign last_rnd  = (rnd_q == nr);

	aes_round u_round (
		.state_in(blk_q), .round_key(rk_q), .inverse(op_q),
		.do_sub(!first_rnd), .do_mix(!first_rnd && !last_rnd), .state_out(rnd_out)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q <= KS_128;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_idx_t'(cfg.index))
				REG_KEY_SIZE: ksize_q <= (cfg.data[1:0] == 2'd3) ? KS_256 : cfg.data[1:0];
				REG_KEY_0:    key_q[0] <= cfg.data;
				REG_KEY_1:    key_q[1] <= cfg.data;
				REG_KEY_2:    key_q[2] <= cfg.data;
				REG_KEY_3:    key_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			sched_ok_q <= 1'b0;
			obusy_q <= 1'b0;
			op_q <= OP_ENC;
			blk_q <= '0;
			rk_q <= '0;
			prev_q <= '0;
			res_q <= '0;
			rnd_q <= '0;
			wcnt_q <= '0;
			widx_q <= '0;
			kphase_q <= '0;
			rcon_q <= RCON_INIT;
		end else begin
			if (out_ch.valid && out_ch.ready && st_q != ST_OUT) obusy_q <= 1'b0;
			if (cfg.valid && cfg.ready && cfg.index <= REG_KEY_3) sched_ok_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						op_q <= in_ch.opcode;
						blk_q <= {in_ch.block_hi, in_ch.block_lo};
						rnd_q <= '0;
						wcnt_q <= '0;
						widx_q <= '0;
						kphase_q <= '0;
						rcon_q <= RCON_INIT;
						st_q <= sched_ok_q ? ST_KRD : ST_EXPRD;
					end
				end
				// load key words directly, then read w[i-nk]
				ST_EXPRD: begin
					if (widx_q < AW'(nk)) begin
						prev_q <= kword;
						widx_q <= widx_q + 1'b1;
					end else begin
						st_q <= ST_EXPWR;
					end
				end
				ST_EXPWR: begin
					prev_q <= new_w;
					if (kphase_q == 3'd0) rcon_q <= gf_dbl(rcon_q);
					kphase_q <= (kphase_q == 3'(nk - 1)) ? 3'd0 : kphase_q + 1'b1;
					widx_q <= widx_q + 1'b1;
					if (widx_q == total - 1'b1) begin
						sched_ok_q <= 1'b1;
						st_q <= ST_KRD;
					end else begin
						st_q <= ST_EXPRD;
					end
				end
				// four reads; data lands in the cycle after each read
				ST_KRD: begin
					if (wcnt_q != 3'd0) rk_q <= {rk_q[95:0], rdata};
					if (wcnt_q == 3'd4) begin
						st_q <= ST_ROUND;
						wcnt_q <= '0;
					end else begin
						wcnt_q <= wcnt_q + 1'b1;
					end
				end
				ST_ROUND: begin
					blk_q <= rnd_out;
					if (last_rnd) begin
						st_q <= ST_OUT;
					end else begin
						rnd_q <= rnd_q + 1'b1;
						st_q <= ST_KRD;
					end
				end
				// load the output register once it is free or being drained
				ST_OUT: begin
					if (!obusy_q || out_ch.ready) begin
						res_q <= blk_q;
						obusy_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the AES block cipher
// Walks a table of directed blocks, then random blocks under several key
// settings and idling phases; every result is checked against a predictor or the table.
// ----------------------------------------------------------------------------
module tb_top;
	import aes_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        op;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        known;
		logic [63:0] exp_hi;
		logic [63:0] exp_lo;
	} vec_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} blk_t;

	logic clk;
	logic arst_n;
	int   errors;

	aes_in_if  in_ch ();
	aes_out_if out_ch ();
	aes_cfg_if cfg ();

	aes_block_cipher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// predictor state
	logic [1:0]  p_ks;
	logic [63:0] p_key [4];
	logic [31:0] p_rk [60];
	blk_t        pending_blocks [$];

	// idling control
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off;

	// generate clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stop a hung run
	initial begin
		#50ms;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic logic [7:0] mul_gf(input logic [7:0] v, input logic [7:0] m);
		logic [7:0] acc;
		acc = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (m[k]) acc ^= v;
			v = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function automatic int key_words();
		return (p_ks == KS_128) ? 4 : ((p_ks == KS_192) ? 6 : 8);
	endfunction

	// build the round-key schedule from the current key
	task automatic build_schedule();
		int nk;
		int total;
		logic [31:0] t;
		logic [7:0] rc;
		nk = key_words();
		total = 4 * (nk + 7);
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			p_rk[i] = (i % 2 == 0) ? p_key[i / 2][63:32] : p_key[i / 2][31:0];
		for (int i = nk; i < total; i++) begin
			t = p_rk[i - 1];
			if (i % nk == 0) begin
				t = {FWD_BOX[t[23:16]], FWD_BOX[t[15:8]], FWD_BOX[t[7:0]],
					FWD_BOX[t[31:24]]} ^ {rc, 24'h0};
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
			end else if (nk > 6 && i % nk == 4) begin
				t = {FWD_BOX[t[31:24]], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]],
					FWD_BOX[t[7:0]]};
			end
			p_rk[i] = p_rk[i - nk] ^ t;
		end
	endtask

	// cipher or inverse cipher of one block; s[r + 4c] is row r, column c
	function automatic blk_t crypt_block(input logic op, input logic [63:0] hi,
			input logic [63:0] lo);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] col [4];
		logic [7:0] fm [4];
		logic [7:0] im [4];
		logic [31:0] w;
		int nr;
		blk_t res;
		fm = '{8'h02, 8'h03, 8'h01, 8'h01};
		im = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		nr = key_words() + 6;
		for (int k = 0; k < 8; k++) begin
			s[k] = hi[63 - 8 * k -: 8];
			s[k + 8] = lo[63 - 8 * k -: 8];
		end
		for (int step = 0; step <= nr; step++) begin
			int rnd;
			rnd = op ? nr - step : step;
			if (step > 0) begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						if (op) t[r + 4 * ((c + r) % 4)] = INV_BOX[s[r + 4 * c]];
						else t[r + 4 * c] = FWD_BOX[s[r + 4 * ((c + r) % 4)]];
				s = t;
				if (!op && step < nr) begin
					for (int c = 0; c < 4; c++) begin
						for (int r = 0; r < 4; r++) col[r] = s[4 * c + r];
						for (int r = 0; r < 4; r++) begin
							s[4 * c + r] = 8'h00;
							for (int k = 0; k < 4; k++)
								s[4 * c + r] ^= mul_gf(col[k], fm[(k + 4 - r) % 4]);
						end
					end
				end
			end
			for (int c = 0; c < 4; c++) begin
				w = p_rk[4 * rnd + c];
				for (int b = 0; b < 4; b++) s[4 * c + b] ^= w[31 - 8 * b -: 8];
			end
			if (op && step > 0 && step < nr) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) col[r] = s[4 * c + r];
					for (int r = 0; r < 4; r++) begin
						s[4 * c + r] = 8'h00;
						for (int k = 0; k < 4; k++)
							s[4 * c + r] ^= mul_gf(col[k], im[(k + 4 - r) % 4]);
					end
				end
			end
		end
		for (int k = 0; k < 8; k++) begin
			res.hi[63 - 8 * k -: 8] = s[k];
			res.lo[63 - 8 * k -: 8] = s[k + 8];
		end
		return res;
	endfunction

	// write one register and mirror it in the predictor
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_KEY_SIZE) p_ks = (val[1:0] == 2'd3) ? KS_256 : val[1:0];
		else if (idx <= REG_KEY_3) p_key[idx - 1] = val;
		@(posedge clk);
	endtask

	task automatic load_key(input logic [1:0] ks, input logic [63:0] k0,
			input logic [63:0] k1, input logic [63:0] k2, input logic [63:0] k3);
		write_reg(REG_KEY_SIZE, {62'h0, ks});
		write_reg(REG_KEY_0, k0);
		write_reg(REG_KEY_1, k1);
		write_reg(REG_KEY_2, k2);
		write_reg(REG_KEY_3, k3);
		build_schedule();
	endtask

	// offer one block and queue its prediction
	task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
			input logic known, input logic [63:0] eh, input logic [63:0] el);
		blk_t b;
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		b = crypt_block(op, hi, lo);
		if (known) begin
			if (b.hi !== eh || b.lo !== el) begin
				$display("%0t predictor disagrees with table: expected %h%h got %h%h",
					$time, eh, el, b.hi, b.lo);
				errors++;
			end
			b.hi = eh;
			b.lo = el;
		end
		pending_blocks.push_back(b);
		in_ch.valid    <= 1'b1;
		in_ch.opcode   <= op;
		in_ch.block_hi <= hi;
		in_ch.block_lo <= lo;
		do @(posedge clk); while (!in_ch.ready);
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (pending_blocks.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic random_blocks(input int n);
		logic op;
		logic [63:0] hi;
		logic [63:0] lo;
		for (int i = 0; i < n; i++) begin
			op = 1'($urandom_range(1));
			hi = {$urandom, $urandom};
			lo = {$urandom, $urandom};
			case ($urandom_range(9))
				0: hi = '0;
				1: lo = '1;
				default: ;
			endcase
			send_block(op, hi, lo, 1'b0, '0, '0);
		end
	endtask

	// check each accepted result against the oldest prediction
	always @(posedge clk) begin
		blk_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t unexpected result %h%h", $time, out_ch.result_hi,
					out_ch.result_lo);
				errors++;
			end else begin
				e = pending_blocks.pop_front();
				if (out_ch.result_hi !== e.hi) begin
					$display("%0t result_hi expected %h actual %h", $time, e.hi,
						out_ch.result_hi);
					errors++;
				end
				if (out_ch.result_lo !== e.lo) begin
					$display("%0t result_lo expected %h actual %h", $time, e.lo,
						out_ch.result_lo);
					errors++;
				end
			end
		end
	end

	// drive receiver ready, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// stimulus
	initial begin
		vec_t tbl [$];
		int phase_idle [4];
		int phase_stall [4];
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_ENC;
		in_ch.block_hi = '0;
		in_ch.block_lo = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_KEY_SIZE;
		cfg.data = '0;
		out_ch.ready = 1'b0;
		p_ks = KS_128;
		for (int i = 0; i < 4; i++) p_key[i] = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero key straight after reset
		build_schedule();
		tbl.push_back('{OP_ENC, 64'h0, 64'h0, 1'b1,
			64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
		tbl.push_back('{OP_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1,
			64'h0, 64'h0});
		tbl.push_back('{OP_ENC, '1, '1, 1'b0, '0, '0});
		tbl.push_back('{OP_DEC, '1, '0, 1'b0, '0, '0});
		foreach (tbl[i]) send_block(tbl[i].op, tbl[i].hi, tbl[i].lo, tbl[i].known,
			tbl[i].exp_hi, tbl[i].exp_lo);
		drain();

		// standard vectors for each key size, key bytes 00 01 02 ...
		tbl.delete();
		load_key(KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
		tbl.push_back('{OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
			64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
		tbl.push_back('{OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
			64'h0011223344556677, 64'h8899aabbccddeeff});
		foreach (tbl[i]) send_block(tbl[i].op, tbl[i].hi, tbl[i].lo, tbl[i].known,
			tbl[i].exp_hi, tbl[i].exp_lo);
		drain();
		tbl.delete();
		load_key(KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, '1);
		tbl.push_back('{OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
			64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191});
		tbl.push_back('{OP_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b1,
			64'h0011223344556677, 64'h8899aabbccddeeff});
		foreach (tbl[i]) send_block(tbl[i].op, tbl[i].hi, tbl[i].lo, tbl[i].known,
			tbl[i].exp_hi, tbl[i].exp_lo);
		drain();
		// key size three acts as 256-bit
		tbl.delete();
		load_key(2'd3, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		tbl.push_back('{OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
			64'h8ea2b7ca516745bf, 64'heafc49904b496089});
		tbl.push_back('{OP_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1,
			64'h0011223344556677, 64'h8899aabbccddeeff});
		foreach (tbl[i]) send_block(tbl[i].op, tbl[i].hi, tbl[i].lo, tbl[i].known,
			tbl[i].exp_hi, tbl[i].exp_lo);
		drain();

		// out-of-range index is ignored; a lone key write forces re-expansion
		write_reg(3'd5, '1);
		write_reg(3'd7, 64'h0123456789abcdef);
		write_reg(REG_KEY_3, '0);
		build_schedule();
		random_blocks(4);
		drain();

		// random phases over key settings and idling mixes
		phase_idle = '{0, 49, 0, 21};
		phase_stall = '{0, 0, 49, 21};
		for (int ph = 0; ph < 8; ph++) begin
			load_key(2'(ph % 3), (ph == 1) ? '1 : {$urandom, $urandom},
				(ph == 1) ? '1 : {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			send_idle_pct = phase_idle[ph % 4];
			recv_stall_pct = phase_stall[ph % 4];
			if (ph == 2) begin
				// long receiver hold-off while blocks keep coming
				@(posedge clk);
				hold_off <= 2000;
			end
			random_blocks(250);
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (pending_blocks.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time,
				pending_blocks.size());
			errors++;
		end
		if (errors == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/aes_pkg.sv
rtl/core/aes_if.sv
rtl/core/aes_ram.sv
rtl/core/aes_round.sv
rtl/core/aes_block_cipher.sv
tb/sv/tb_top.sv
